>>> sv/mts_pkg.sv
`default_nettype none

package mts_pkg;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int CMD_W    = 2;
    localparam int EIDX_W   = 8;
    localparam int FREQ_W   = 21;
    localparam int EDUR_W   = 16;
    localparam int TDUR_W   = 24;
    localparam int PSTATE_W = 3;
    localparam int NOTE_W   = 9;
    localparam int LEN_W    = 9;
    localparam int SPEED_W  = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Wide index used for compares against the melody depth (depth up to 4096)
    localparam int WIDX_W = 13;

    // Duration divider: numerator dur*512 + speed, divisor 2*speed
    localparam int NUM_W     = 26;
    localparam int REM_W     = 14;
    localparam int DIV_STEPS = 26;
    localparam int DCNT_W    = 5;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MELODY_LENGTH = 2'd0,
        CFG_MELODY_LOADED = 2'd1,
        CFG_SPEED_Q8      = 2'd2
    } t_cfg_idx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIRE  = 2'd0,
        ACT_CMD   = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [CMD_W-1:0] {
        CMD_STOP  = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_PAUSE = 2'd2
    } t_cmd;

    typedef enum logic [PSTATE_W-1:0] {
        PS_WAIT_START  = 3'd0,
        PS_WAIT_NOTE   = 3'd1,
        PS_PLAY_NOTE   = 3'd2,
        PS_PAUSE       = 3'd3,
        PS_WAIT_MELODY = 3'd4
    } t_pstate;

    typedef enum logic [2:0] {
        C_IDLE = 3'd0,
        C_EVAL = 3'd1,
        C_READ = 3'd2,
        C_LOAD = 3'd3,
        C_DIV  = 3'd4,
        C_DONE = 3'd5
    } t_ctrl_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic eval;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic start_note;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/mts_in_if.sv
`default_nettype none

interface mts_in_if;
    import mts_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                note_timeout;
    logic [CMD_W-1:0]    command;
    logic [EIDX_W-1:0]   entry_index;
    logic [FREQ_W-1:0]   entry_frequency;
    logic [EDUR_W-1:0]   entry_duration;

    modport source (
        output valid, action, note_timeout, command, entry_index,
               entry_frequency, entry_duration,
        input  ready
    );

    modport sink (
        input  valid, action, note_timeout, command, entry_index,
               entry_frequency, entry_duration,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/mts_out_if.sv
`default_nettype none

interface mts_out_if;
    import mts_pkg::*;

    logic                valid;
    logic                ready;
    logic                tone_start;
    logic                tone_stop;
    logic [FREQ_W-1:0]   tone_frequency;
    logic [TDUR_W-1:0]   tone_duration;
    logic [PSTATE_W-1:0] player_state;
    logic [CMD_W-1:0]    current_command;
    logic                is_playing;

    modport source (
        output valid, tone_start, tone_stop, tone_frequency, tone_duration,
               player_state, current_command, is_playing,
        input  ready
    );

    modport sink (
        input  valid, tone_start, tone_stop, tone_frequency, tone_duration,
               player_state, current_command, is_playing,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/melody_tone_sequencer.sv
`default_nettype none

// Melody player: requests write melody entries, set the play/pause/stop
// command, or fire the player state machine with the note-timer flag; each
// request returns one result with any tone start (its frequency, and its duration
// scaled by the speed register) or tone stop, plus the player status. One
// request is handled at a time. A request that starts no note goes from
// evaluation straight to its result. One that starts a note first does a
// registered read of the melody memory and then runs the 26-step bit-serial
// divider that scales the duration. The next request is accepted as soon as
// a result sits in the output register, and the block holds in its final
// step until the output register frees up.
module melody_tone_sequencer
    import mts_pkg::*;
#(
    parameter int MELODY_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mts_in_if.sink                     i_in,
    mts_out_if.source                  o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    mts_datapath #(
        .MELODY_DEPTH (MELODY_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> sv/mts_ram.sv
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/mts_datapath.sv
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int MELODY_DEPTH = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    mts_in_if.sink                     i_in,
    mts_out_if.source                  o_out
);

    localparam int AW    = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
    localparam int ENT_W = FREQ_W + EDUR_W;
    localparam logic [WIDX_W-1:0] DEPTH_W = WIDX_W'(MELODY_DEPTH);

    // Configuration registers
    logic [LEN_W-1:0]   r_length;
    logic               r_loaded;
    logic [SPEED_W-1:0] r_speed;

    // Latched request
    logic [ACTION_W-1:0] r_action;
    logic                r_timeout;
    logic [CMD_W-1:0]    r_req_cmd;
    logic [EIDX_W-1:0]   r_eidx;
    logic [FREQ_W-1:0]   r_efreq;
    logic [EDUR_W-1:0]   r_edur;

    // Player state
    t_pstate            r_pstate;
    t_cmd               r_ucmd;
    logic [NOTE_W-1:0]  r_next_note;

    // Per-request results
    logic               r_start;
    logic               r_stop;
    logic [NOTE_W-1:0]  r_rd_idx;
    logic [FREQ_W-1:0]  r_freq;

    // Divider
    logic [NUM_W-1:0]   r_num;
    logic [REM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quot;
    logic [DCNT_W-1:0]  r_cnt;

    // Output register
    logic                r_out_valid;
    logic                r_out_start;
    logic                r_out_stop;
    logic [FREQ_W-1:0]   r_out_freq;
    logic [TDUR_W-1:0]   r_out_dur;
    logic [PSTATE_W-1:0] r_out_pstate;
    logic [CMD_W-1:0]    r_out_cmd;
    logic                r_out_playing;

    // Transition evaluation
    t_pstate            ev_pstate;
    t_cmd               ev_ucmd;
    logic [NOTE_W-1:0]  ev_next;
    logic [NOTE_W-1:0]  ev_idx;
    logic               ev_start;
    logic               ev_stop;
    logic               ev_we;

    // Memory access
    logic [WIDX_W-1:0]  waddr_w;
    logic [WIDX_W-1:0]  raddr_w;
    logic [ENT_W-1:0]   rdata;
    logic               rd_in_range;
    logic [FREQ_W-1:0]  ld_freq;
    logic [EDUR_W-1:0]  ld_dur;

    // Divider step
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   divisor;
    logic               rem_ge;
    logic [TDUR_W-1:0]  dur_sat;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_loaded <= 1'b0;
            r_speed  <= SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MELODY_LENGTH: r_length <= LEN_W'(i_cfg_data);
                CFG_MELODY_LOADED: r_loaded <= i_cfg_data[0];
                CFG_SPEED_Q8:      r_speed  <= SPEED_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action  <= i_in.action;
            r_timeout <= i_in.note_timeout;
            r_req_cmd <= i_in.command;
            r_eidx    <= i_in.entry_index;
            r_efreq   <= i_in.entry_frequency;
            r_edur    <= i_in.entry_duration;
        end
    end

    // Evaluate the player transition for the latched request
    always_comb begin
        ev_pstate = r_pstate;
        ev_ucmd   = r_ucmd;
        ev_next   = r_next_note;
        ev_idx    = r_next_note;
        ev_start  = 1'b0;
        ev_stop   = 1'b0;
        ev_we     = 1'b0;
        case (r_action)
            ACT_WRITE: begin
                ev_we = (WIDX_W'(r_eidx) < DEPTH_W);
            end
            ACT_CMD: begin
                if (r_req_cmd == CMD_STOP || r_req_cmd == CMD_PLAY ||
                    r_req_cmd == CMD_PAUSE) begin
                    ev_ucmd = t_cmd'(r_req_cmd);
                    if (r_req_cmd == CMD_STOP) begin
                        ev_next = '0;
                    end
                end
            end
            ACT_FIRE: begin
                case (r_pstate)
                    PS_WAIT_START, PS_WAIT_MELODY: begin
                        if (r_loaded && r_ucmd == CMD_PLAY) begin
                            ev_start  = 1'b1;
                            ev_idx    = '0;
                            ev_next   = r_next_note + 1'b1;
                            ev_pstate = PS_WAIT_NOTE;
                        end
                    end
                    PS_WAIT_NOTE: begin
                        if (r_timeout) begin
                            ev_stop   = 1'b1;
                            ev_pstate = PS_PLAY_NOTE;
                        end
                    end
                    PS_PLAY_NOTE: begin
                        if (r_ucmd == CMD_PAUSE) begin
                            ev_stop   = 1'b1;
                            ev_pstate = PS_PAUSE;
                        end else if (r_ucmd == CMD_STOP) begin
                            ev_stop   = 1'b1;
                            ev_next   = '0;
                            ev_pstate = PS_WAIT_START;
                        end else if (r_next_note >= r_length) begin
                            ev_stop   = 1'b1;
                            ev_next   = '0;
                            ev_ucmd   = CMD_STOP;
                            ev_pstate = PS_WAIT_MELODY;
                        end else if (r_ucmd == CMD_PLAY) begin
                            ev_start  = 1'b1;
                            ev_idx    = r_next_note;
                            ev_next   = r_next_note + 1'b1;
                            ev_pstate = PS_WAIT_NOTE;
                        end
                    end
                    PS_PAUSE: begin
                        if (r_ucmd == CMD_PLAY) begin
                            ev_pstate = PS_PLAY_NOTE;
                        end
                    end
                    default: begin
                        ev_pstate = PS_WAIT_START;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Commit the player state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate    <= PS_WAIT_START;
            r_ucmd      <= CMD_STOP;
            r_next_note <= '0;
        end else if (i_cmd.eval) begin
            r_pstate    <= ev_pstate;
            r_ucmd      <= ev_ucmd;
            r_next_note <= ev_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_start  <= ev_start;
            r_stop   <= ev_stop;
            r_rd_idx <= ev_idx;
        end
    end

    // Melody store: frequency and duration side by side
    assign waddr_w = WIDX_W'(r_eidx);
    assign raddr_w = WIDX_W'(r_rd_idx);

    mts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MELODY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.eval && ev_we),
        .i_waddr (waddr_w[AW-1:0]),
        .i_wdata ({r_efreq, r_edur}),
        .i_raddr (raddr_w[AW-1:0]),
        .o_rdata (rdata)
    );

    // Note index beyond the store reads as zero
    assign rd_in_range = (raddr_w < DEPTH_W);
    assign ld_freq     = rd_in_range ? rdata[ENT_W-1:EDUR_W] : '0;
    assign ld_dur      = rd_in_range ? rdata[EDUR_W-1:0] : '0;

    // Restoring division, one quotient bit per cycle
    assign rem_sh  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign divisor = {1'b0, r_speed, 1'b0};
    assign rem_ge  = (rem_sh >= divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_cnt <= DCNT_W'(DIV_STEPS);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_freq <= ld_freq;
            r_num  <= NUM_W'({ld_dur, 9'b0}) + NUM_W'(r_speed);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= rem_ge ? (rem_sh - divisor) : rem_sh;
            r_quot <= {r_quot[NUM_W-2:0], rem_ge};
        end
    end

    // Saturate; a zero speed gives an all-ones quotient and saturates too
    assign dur_sat = (r_quot[NUM_W-1:TDUR_W] != '0) ? '1 : r_quot[TDUR_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_start   <= r_start;
            r_out_stop    <= r_stop;
            r_out_freq    <= r_start ? r_freq : '0;
            r_out_dur     <= r_start ? dur_sat : '0;
            r_out_pstate  <= r_pstate;
            r_out_cmd     <= r_ucmd;
            r_out_playing <= (r_ucmd == CMD_PLAY);
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.tone_start      = r_out_start;
    assign o_out.tone_stop       = r_out_stop;
    assign o_out.tone_frequency  = r_out_freq;
    assign o_out.tone_duration   = r_out_dur;
    assign o_out.player_state    = r_out_pstate;
    assign o_out.current_command = r_out_cmd;
    assign o_out.is_playing      = r_out_playing;

    // Status to the controller
    assign o_status.start_note = ev_start;
    assign o_status.div_last   = (r_cnt == DCNT_W'(1));
    assign o_status.out_free   = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

>>> sv/mts_ctrl.sv
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one request: evaluate, optionally read and scale, then deliver
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            C_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = C_EVAL;
                end
            end
            C_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.start_note ? C_READ : C_DONE;
            end
            C_READ: begin
                n_state = C_LOAD;
            end
            C_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = C_DIV;
            end
            C_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = C_DONE;
                end
            end
            C_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> test/tone_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps its own copy of the
// player, and compares every result against the oldest predicted one.
module tone_checker
    import mts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mts_in_if                          i_req,
    mts_out_if                         i_res,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_notes
);

    localparam int DEPTH = 256;

    typedef struct packed {
        logic              start;
        logic              stop;
        logic [FREQ_W-1:0] freq;
        logic [TDUR_W-1:0] dur;
        t_pstate           pstate;
        logic [CMD_W-1:0]  cmd;
        logic              playing;
    } t_tone;

    // Shadow configuration
    logic [LEN_W-1:0]   melody_len;
    logic               melody_on;
    logic [SPEED_W-1:0] speed;

    // Shadow player state
    t_pstate            player;
    t_cmd               user_cmd;
    logic [NOTE_W-1:0]  note_idx;
    logic [FREQ_W-1:0]  freq_mem [DEPTH];
    logic [EDUR_W-1:0]  dur_mem  [DEPTH];

    t_tone expected_tones [$];
    int    errors = 0;
    int    notes  = 0;

    // Duration in ms scaled by speed, rounded to nearest, saturated to 24 bits
    function automatic logic [TDUR_W-1:0] scale_ms(logic [EDUR_W-1:0] ms);
        longint unsigned num;
        longint unsigned quot;
        if (speed == '0)
            return '1;
        num  = longint'(ms) * 512 + longint'(speed);
        quot = num / (longint'(speed) * 2);
        return (quot > longint'({TDUR_W{1'b1}})) ? '1 : quot[TDUR_W-1:0];
    endfunction

    // Apply one request to the shadow player and return the result it yields
    function automatic t_tone step_player(t_action act, logic timeout,
                                          logic [CMD_W-1:0] cmd,
                                          logic [EIDX_W-1:0] eidx,
                                          logic [FREQ_W-1:0] efreq,
                                          logic [EDUR_W-1:0] edur);
        t_tone             r;
        logic              go;
        logic [NOTE_W-1:0] pick;
        r    = '0;
        go   = 1'b0;
        pick = '0;
        case (act)
            ACT_WRITE: begin
                freq_mem[eidx] = efreq;
                dur_mem[eidx]  = edur;
            end
            ACT_CMD: begin
                // an unused command code changes nothing
                if (cmd <= CMD_PAUSE) begin
                    user_cmd = t_cmd'(cmd);
                    if (cmd == CMD_STOP)
                        note_idx = '0;
                end
            end
            ACT_FIRE: begin
                case (player)
                    PS_WAIT_START, PS_WAIT_MELODY: begin
                        if (melody_on && user_cmd == CMD_PLAY) begin
                            go     = 1'b1;
                            pick   = '0;
                            player = PS_WAIT_NOTE;
                        end
                    end
                    PS_WAIT_NOTE: begin
                        if (timeout) begin
                            r.stop = 1'b1;
                            player = PS_PLAY_NOTE;
                        end
                    end
                    PS_PLAY_NOTE: begin
                        if (user_cmd == CMD_PAUSE) begin
                            r.stop = 1'b1;
                            player = PS_PAUSE;
                        end else if (user_cmd == CMD_STOP) begin
                            r.stop   = 1'b1;
                            note_idx = '0;
                            player   = PS_WAIT_START;
                        end else if (note_idx >= melody_len) begin
                            // end of melody: drop the command back to stop
                            r.stop   = 1'b1;
                            note_idx = '0;
                            user_cmd = CMD_STOP;
                            player   = PS_WAIT_MELODY;
                        end else if (user_cmd == CMD_PLAY) begin
                            go     = 1'b1;
                            pick   = note_idx;
                            player = PS_WAIT_NOTE;
                        end
                    end
                    PS_PAUSE: begin
                        if (user_cmd == CMD_PLAY)
                            player = PS_PLAY_NOTE;
                    end
                    default: player = PS_WAIT_START;
                endcase
            end
            default: ;
        endcase

        // Start a note; indexes past the melody store read as silence
        if (go) begin
            r.start = 1'b1;
            if (pick < DEPTH) begin
                r.freq = freq_mem[pick[EIDX_W-1:0]];
                r.dur  = scale_ms(dur_mem[pick[EIDX_W-1:0]]);
            end else begin
                r.dur  = scale_ms('0);
            end
            note_idx = note_idx + 1'b1;
        end

        r.pstate  = player;
        r.cmd     = user_cmd;
        r.playing = (user_cmd == CMD_PLAY);
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_tone want;
        t_tone got;
        if (!i_rst_n) begin
            melody_len = '0;
            melody_on  = 1'b0;
            speed      = SPEED_RESET;
            player     = PS_WAIT_START;
            user_cmd   = CMD_STOP;
            note_idx   = '0;
            for (int k = 0; k < DEPTH; k++) begin
                freq_mem[k] = '0;
                dur_mem[k]  = '0;
            end
            expected_tones.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MELODY_LENGTH: melody_len = i_cfg_data[LEN_W-1:0];
                    CFG_MELODY_LOADED: melody_on  = i_cfg_data[0];
                    CFG_SPEED_Q8:      speed      = i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            // Predict on every accepted request
            if (i_req.valid && i_req.ready)
                expected_tones.push_back(step_player(t_action'(i_req.action),
                    i_req.note_timeout, i_req.command, i_req.entry_index,
                    i_req.entry_frequency, i_req.entry_duration));

            // Compare every accepted result
            if (i_res.valid && i_res.ready) begin
                got.start   = i_res.tone_start;
                got.stop    = i_res.tone_stop;
                got.freq    = i_res.tone_frequency;
                got.dur     = i_res.tone_duration;
                got.pstate  = t_pstate'(i_res.player_state);
                got.cmd     = i_res.current_command;
                got.playing = i_res.is_playing;
                if (expected_tones.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch, expected none, actual state %0d",
                             $time, got.pstate);
                end else begin
                    want = expected_tones.pop_front();
                    if (want.start)
                        notes++;
                    check_field("tone_start", 32'(want.start), 32'(got.start));
                    check_field("tone_stop", 32'(want.stop), 32'(got.stop));
                    check_field("tone_frequency", 32'(want.freq), 32'(got.freq));
                    check_field("tone_duration", 32'(want.dur), 32'(got.dur));
                    check_field("player_state", 32'(want.pstate), 32'(got.pstate));
                    check_field("current_command", 32'(want.cmd), 32'(got.cmd));
                    check_field("is_playing", 32'(want.playing), 32'(got.playing));
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_tones.size();
        o_notes   <= notes;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import mts_pkg::*;

    localparam int                 LIMIT_CYCLES     = 1_000_000;
    localparam int                 SETTLE_CYCLES    = 40;
    localparam int                 DEPTH            = 256;
    localparam int                 PHASE_ITEMS      = 120;
    localparam int                 LONG_HOLD_AFTER  = 400;
    localparam int                 LONG_HOLD_CYCLES = 500;
    localparam logic [CMD_W-1:0]   CMD_UNUSED       = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mts_in_if  req_if ();
    mts_out_if res_if ();

    int errors;
    int pending;
    int notes;
    int requests_sent  = 0;
    int settings_used  = 0;
    bit idle_on        = 1'b1;
    bit tail           = 1'b0;

    melody_tone_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    tone_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .i_res       (res_if),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_notes     (notes)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold to back up the block
    initial begin : result_drain
        int stall_left;
        int results_seen;
        bit long_hold_done;
        stall_left     = 0;
        results_seen   = 0;
        long_hold_done = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                results_seen++;
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic set_reg(t_cfg_idx idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(int len, int loaded, int speed);
        set_reg(CFG_MELODY_LENGTH, len);
        set_reg(CFG_MELODY_LOADED, loaded);
        set_reg(CFG_SPEED_Q8, speed);
        settings_used++;
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one request and hold it until accepted
    task automatic send_req(t_action act, logic timeout, logic [CMD_W-1:0] cmd,
                            logic [EIDX_W-1:0] idx, logic [FREQ_W-1:0] freq,
                            logic [EDUR_W-1:0] dur);
        if (!tail && requests_sent % 50 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.action          <= act;
        req_if.note_timeout    <= timeout;
        req_if.command         <= cmd;
        req_if.entry_index     <= idx;
        req_if.entry_frequency <= freq;
        req_if.entry_duration  <= dur;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [31:0] corner_value(logic [31:0] all_ones);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return all_ones;
            default: return $urandom & all_ones;
        endcase
    endfunction

    // Mostly fires and play commands so melodies actually progress
    task automatic send_random(output bit counted);
        int               roll;
        t_action          act;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            act = ACT_FIRE;
        else if (roll < 70)
            act = ACT_CMD;
        else if (roll < 95)
            act = ACT_WRITE;
        else
            act = ACT_NONE;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            cmd = CMD_PLAY;
        else if (roll < 75)
            cmd = CMD_PAUSE;
        else if (roll < 90)
            cmd = CMD_STOP;
        else
            cmd = CMD_UNUSED;
        send_req(act, $urandom_range(0, 3) != 0, cmd,
                 EIDX_W'($urandom_range(0, DEPTH - 1)),
                 FREQ_W'(corner_value(32'({FREQ_W{1'b1}}))),
                 EDUR_W'(corner_value(32'({EDUR_W{1'b1}}))));
        counted = (act != ACT_NONE);
    endtask

    task automatic run_phase(int len, int loaded, int speed);
        int done;
        bit counted;
        settle();
        configure(len, loaded, speed);
        done = 0;
        while (done < PHASE_ITEMS) begin
            send_random(counted);
            if (counted)
                done++;
        end
    endtask

    initial begin : stimulus
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= '0;
        cfg_data               <= '0;
        req_if.valid           <= 1'b0;
        req_if.action          <= ACT_NONE;
        req_if.note_timeout    <= 1'b0;
        req_if.command         <= CMD_STOP;
        req_if.entry_index     <= '0;
        req_if.entry_frequency <= '0;
        req_if.entry_duration  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: not loaded, so nothing may start
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_NONE, 1'b1, '1, '1, '1, '1);
        send_req(ACT_CMD, 1'b0, CMD_UNUSED, '0, '0, '0);
        send_req(ACT_CMD, 1'b0, CMD_PLAY, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        // Short melody with extreme entries
        send_req(ACT_WRITE, 1'b0, CMD_STOP, 8'd0, '1, '1);
        send_req(ACT_WRITE, 1'b0, CMD_STOP, 8'd1, '0, '0);
        send_req(ACT_WRITE, 1'b0, CMD_STOP, 8'd2, 21'h0AAAAA, 16'h5555);
        send_req(ACT_WRITE, 1'b0, CMD_STOP, 8'd255, 21'h155555, 16'hAAAA);
        settle();
        configure(3, 1, 256);
        // Play, wait, pause, resume, run off the end
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_CMD, 1'b0, CMD_PAUSE, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_CMD, 1'b0, CMD_PLAY, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        // Restart from wait melody, then stop command mid-note
        send_req(ACT_CMD, 1'b0, CMD_PLAY, '0, '0, '0);
        send_req(ACT_FIRE, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_CMD, 1'b0, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);
        send_req(ACT_FIRE, 1'b1, CMD_STOP, '0, '0, '0);

        // Fill the whole melody store so any later length is safe to play
        for (int k = 0; k < DEPTH; k++)
            send_req(ACT_WRITE, 1'($urandom_range(0, 1)), CMD_W'($urandom_range(0, 3)),
                     EIDX_W'(k),
                     FREQ_W'(corner_value(32'({FREQ_W{1'b1}}))),
                     EDUR_W'(corner_value(32'({EDUR_W{1'b1}}))));
        settle();
        configure(DEPTH, 1, 4095);

        // Play the full-length melody to its end, with writes and no-ops mixed in
        send_req(ACT_CMD, 1'b0, CMD_PLAY, '0, '0, '0);
        for (int k = 0; k < 2 * DEPTH + 4; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_req($urandom_range(0, 1) ? ACT_WRITE : ACT_NONE,
                         1'($urandom_range(0, 1)), CMD_W'($urandom_range(0, 3)),
                         EIDX_W'($urandom_range(0, DEPTH - 1)),
                         FREQ_W'(corner_value(32'({FREQ_W{1'b1}}))),
                         EDUR_W'(corner_value(32'({EDUR_W{1'b1}}))));
            send_req(ACT_FIRE, 1'b1, CMD_W'($urandom_range(0, 3)),
                     EIDX_W'($urandom_range(0, DEPTH - 1)),
                     FREQ_W'($urandom), EDUR_W'($urandom));
        end

        // Random traffic across several register settings
        run_phase(0, 1, 256);
        run_phase(5, 1, 1);
        run_phase(12, 1, 0);
        run_phase(7, 0, 300);
        run_phase($urandom_range(1, 20), 1, $urandom_range(1, 4095));
        tail    = 1'b1;
        idle_on = 1'b0;
        run_phase(3, 1, 256);
        settle();

        $display("tb: %0d requests across %0d register settings, %0d notes started",
                 requests_sent, settings_used, notes);
        $display("tb: included a full 256-note melody, zero and extreme speeds, long result stall");
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> melody_tone_sequencer.f
sv/mts_pkg.sv
sv/mts_in_if.sv
sv/mts_out_if.sv
sv/mts_ram.sv
sv/mts_datapath.sv
sv/mts_ctrl.sv
sv/melody_tone_sequencer.sv
test/tone_checker.sv
test/tb.sv
